// ===== src/uct_child_select_unit_defines.svh =====
// assertion macros shared by the uct child select unit
// no dependencies
`ifndef UCT_CHILD_SELECT_UNIT_DEFINES_SVH
`define UCT_CHILD_SELECT_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define UCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define UCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/ucs_pkg.sv =====
// shared types and constants for the uct child select unit
// no dependencies
package ucs_pkg;

    localparam int MaxChildren = 64;
    localparam int PosW = $clog2(MaxChildren + 1);
    localparam int IdxW = 6;
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic [15:0] WeightReset = 16'd5793;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_LOGN,
        ST_LOGF,
        ST_LN,
        ST_RATIO,
        ST_SQRT,
        ST_EXPL,
        ST_SUM,
        ST_CMP
    } t_state;

    // shared unit operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIV,
        OP_SQR,
        OP_SQRT
    } t_op;

    // shared unit command
    typedef struct packed {
        logic        go;
        t_op         op;
        logic [63:0] a;
        logic [31:0] b;
    } t_unit_cmd;

    // shared unit status
    typedef struct packed {
        logic        done;
        logic [63:0] q;
        logic [63:0] r;
    } t_unit_sts;

endpackage

// ===== src/ucs_shared_unit.sv =====
// shared iterative unit: restoring divide, square root and 32x32 multiply
// depends on ucs_pkg
module ucs_shared_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ucs_pkg::t_unit_cmd i_cmd,
    output ucs_pkg::t_unit_sts o_sts
);

    logic        r_busy, n_busy;
    ucs_pkg::t_op r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [31:0] r_b, n_b;
    logic [63:0] r_a, n_a;
    logic        r_done, n_done;
    logic [64:0] w_trial;
    logic [65:0] w_strial;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ucs_pkg::OP_NONE;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_b   <= n_b;
        r_a   <= n_a;
    end

    // one quotient or root bit per cycle; a multiply takes a single step
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_q      = r_q;
        n_rem    = r_rem;
        n_b      = r_b;
        n_a      = r_a;
        w_trial  = '0;
        w_strial = '0;
        if (i_cmd.go) begin
            n_op  = i_cmd.op;
            n_a   = i_cmd.a;
            n_b   = i_cmd.b;
            n_q   = '0;
            n_rem = '0;
            n_busy = 1'b1;
            unique case (i_cmd.op)
                ucs_pkg::OP_DIV:  n_cnt = 7'd64;
                ucs_pkg::OP_SQRT: n_cnt = 7'd32;
                default:          n_cnt = 7'd1;
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                ucs_pkg::OP_DIV: begin
                    w_trial = {r_rem[63:0], r_a[63]};
                    n_a     = {r_a[62:0], 1'b0};
                    if (w_trial >= {33'd0, r_b}) begin
                        n_rem = w_trial - {33'd0, r_b};
                        n_q   = {r_q[62:0], 1'b1};
                    end else begin
                        n_rem = w_trial;
                        n_q   = {r_q[62:0], 1'b0};
                    end
                end
                ucs_pkg::OP_SQRT: begin
                    w_strial = {r_rem[63:0], r_a[63:62]} - {r_q[63:0], 2'b01};
                    n_a      = {r_a[61:0], 2'b00};
                    if (!w_strial[65]) begin
                        n_rem = w_strial[64:0];
                        n_q   = {r_q[62:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[62:0], r_a[63:62]};
                        n_q   = {r_q[62:0], 1'b0};
                    end
                end
                ucs_pkg::OP_SQR: begin
                    n_q = r_a[31:0] * {32'd0, r_b};
                end
                default: n_q = r_q;
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.q    = r_q;
    assign o_sts.r    = r_rem[63:0];

endmodule

// ===== src/ucs_sequencer.sv =====
// sequencer for one child score and running best selection
// depends on ucs_pkg, ucs_shared_unit, uct_child_select_unit_defines.svh
`include "uct_child_select_unit_defines.svh"
module ucs_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_weight,
    input  logic [31:0] i_child_reward_sum,
    input  logic [23:0] i_child_visits,
    input  logic [23:0] i_parent_visits,
    input  logic        i_last_child,
    input  logic        i_no_children,
    output logic        o_busy,
    output logic        o_valid,
    output logic [5:0]  o_best_index,
    output logic        o_found,
    output logic [31:0] o_best_score
);

    ucs_pkg::t_state r_state, n_state;
    ucs_pkg::t_unit_cmd w_cmd;
    ucs_pkg::t_unit_sts w_sts;

    logic [31:0] r_reward, n_reward;
    logic [23:0] r_cv, n_cv;
    logic [23:0] r_pv, n_pv;
    logic        r_last, n_last;
    logic        r_neg, n_neg;
    logic [31:0] r_mean, n_mean;
    logic [4:0]  r_e, n_e;
    logic [32:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  r_it, n_it;
    logic [63:0] r_tmp, n_tmp;
    logic [31:0] r_score, n_score;
    logic [31:0] r_best, n_best;
    logic [ucs_pkg::IdxW-1:0] r_bidx, n_bidx;
    logic [ucs_pkg::PosW-1:0] r_pos, n_pos;
    logic        r_seen, n_seen;
    logic        r_valid, n_valid;
    logic [5:0]  r_oidx, n_oidx;
    logic        r_ofound, n_ofound;
    logic [31:0] r_oscore, n_oscore;
    logic        r_go, n_go;
    ucs_pkg::t_op r_op, n_op;
    logic [63:0] r_a, n_a;
    logic [31:0] r_b, n_b;

    logic [4:0]  w_top;
    logic [63:0] w_mq;
    logic signed [33:0] w_sum;

    ucs_shared_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts)
    );

    assign w_cmd.go = r_go;
    assign w_cmd.op = r_op;
    assign w_cmd.a  = r_a;
    assign w_cmd.b  = r_b;

    // top set bit of the parent count
    always_comb begin
        w_top = '0;
        for (int i = 0; i < 24; i++) begin
            if (r_pv[i]) w_top = 5'(i);
        end
    end

    assign w_mq   = w_sts.q;
    assign w_sum  = $signed({{2{r_mean[31]}}, r_mean}) + $signed({2'b00, r_tmp[31:0]});

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ucs_pkg::ST_IDLE;
            r_best   <= 32'h8000_0000;
            r_bidx   <= '0;
            r_pos    <= '0;
            r_seen   <= 1'b0;
            r_valid  <= 1'b0;
            r_go     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_best   <= n_best;
            r_bidx   <= n_bidx;
            r_pos    <= n_pos;
            r_seen   <= n_seen;
            r_valid  <= n_valid;
            r_go     <= n_go;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_reward <= n_reward;
        r_cv     <= n_cv;
        r_pv     <= n_pv;
        r_last   <= n_last;
        r_neg    <= n_neg;
        r_mean   <= n_mean;
        r_e      <= n_e;
        r_m      <= n_m;
        r_frac   <= n_frac;
        r_it     <= n_it;
        r_tmp    <= n_tmp;
        r_score  <= n_score;
        r_oidx   <= n_oidx;
        r_ofound <= n_ofound;
        r_oscore <= n_oscore;
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
    end

    // next state and outputs
    always_comb begin
        n_state  = r_state;
        n_reward = r_reward;
        n_cv     = r_cv;
        n_pv     = r_pv;
        n_last   = r_last;
        n_neg    = r_neg;
        n_mean   = r_mean;
        n_e      = r_e;
        n_m      = r_m;
        n_frac   = r_frac;
        n_it     = r_it;
        n_tmp    = r_tmp;
        n_score  = r_score;
        n_best   = r_best;
        n_bidx   = r_bidx;
        n_pos    = r_pos;
        n_seen   = r_seen;
        n_valid  = 1'b0;
        n_oidx   = r_oidx;
        n_ofound = r_ofound;
        n_oscore = r_oscore;
        n_go     = 1'b0;
        n_op     = r_op;
        n_a      = r_a;
        n_b      = r_b;
        unique case (r_state)
            ucs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_reward = i_child_reward_sum;
                    n_cv     = i_child_visits;
                    n_pv     = i_parent_visits;
                    n_last   = i_last_child;
                    if (i_no_children || r_pos >= ucs_pkg::PosW'(ucs_pkg::MaxChildren)) begin
                        if (i_no_children || i_last_child) begin
                            n_valid  = 1'b1;
                            n_oidx   = r_seen ? 6'(r_bidx) : 6'd0;
                            n_ofound = r_seen;
                            n_oscore = r_seen ? r_best : 32'd0;
                            n_best   = 32'h8000_0000;
                            n_bidx   = '0;
                            n_pos    = '0;
                            n_seen   = 1'b0;
                        end
                    end else if (i_child_visits == 24'd0) begin
                        n_score = 32'h7FFF_FFFF;
                        n_state = ucs_pkg::ST_CMP;
                    end else begin
                        n_neg   = i_child_reward_sum[31];
                        n_go    = 1'b1;
                        n_op    = ucs_pkg::OP_DIV;
                        n_a     = {32'd0, i_child_reward_sum[31] ?
                                   (~i_child_reward_sum + 32'd1) : i_child_reward_sum};
                        n_b     = {8'd0, i_child_visits};
                        n_state = ucs_pkg::ST_MEAN;
                    end
                end
            end
            ucs_pkg::ST_MEAN: begin
                if (w_sts.done) begin
                    n_mean = r_neg ? (~w_sts.q[31:0] + 32'd1) : w_sts.q[31:0];
                    if (r_pv == 24'd0) begin
                        n_tmp   = '0;
                        n_state = ucs_pkg::ST_SUM;
                    end else begin
                        n_e     = w_top;
                        n_m     = 33'({r_pv, 8'd0} << (5'd23 - w_top));
                        n_frac  = '0;
                        n_it    = '0;
                        n_state = ucs_pkg::ST_LOGN;
                    end
                end
            end
            ucs_pkg::ST_LOGN: begin
                // launch one mantissa squaring
                n_go    = 1'b1;
                n_op    = ucs_pkg::OP_SQR;
                n_a     = {32'd0, r_m[31:0]};
                n_b     = r_m[31:0];
                n_state = ucs_pkg::ST_LOGF;
            end
            ucs_pkg::ST_LOGF: begin
                if (w_sts.done) begin
                    if (w_mq[63]) begin
                        n_frac = {r_frac[14:0], 1'b1};
                        n_m    = {1'b0, w_mq[63:32]};
                    end else begin
                        n_frac = {r_frac[14:0], 1'b0};
                        n_m    = {1'b0, w_mq[62:31]};
                    end
                    n_it = r_it + 5'd1;
                    if (r_it == 5'd15) begin
                        n_go    = 1'b1;
                        n_op    = ucs_pkg::OP_SQR;
                        n_a     = {43'd0, r_e, (w_mq[63] ? {r_frac[14:0], 1'b1}
                                                        : {r_frac[14:0], 1'b0})};
                        n_b     = ucs_pkg::Ln2Q32;
                        n_state = ucs_pkg::ST_LN;
                    end else begin
                        n_state = ucs_pkg::ST_LOGN;
                    end
                end
            end
            ucs_pkg::ST_LN: begin
                if (w_sts.done) begin
                    n_go    = 1'b1;
                    n_op    = ucs_pkg::OP_DIV;
                    n_a     = {16'd0, w_mq[63:32], 16'd0};
                    n_b     = {8'd0, r_cv};
                    n_state = ucs_pkg::ST_RATIO;
                end
            end
            ucs_pkg::ST_RATIO: begin
                if (w_sts.done) begin
                    n_go    = 1'b1;
                    n_op    = ucs_pkg::OP_SQRT;
                    n_a     = w_sts.q;
                    n_state = ucs_pkg::ST_SQRT;
                end
            end
            ucs_pkg::ST_SQRT: begin
                if (w_sts.done) begin
                    n_go    = 1'b1;
                    n_op    = ucs_pkg::OP_SQR;
                    n_a     = {48'd0, i_weight};
                    n_b     = w_sts.q[31:0];
                    n_state = ucs_pkg::ST_EXPL;
                end
            end
            ucs_pkg::ST_EXPL: begin
                if (w_sts.done) begin
                    n_tmp   = {12'd0, w_mq[63:12]};
                    n_state = ucs_pkg::ST_SUM;
                end
            end
            ucs_pkg::ST_SUM: begin
                // saturate mean plus exploration term
                if (r_tmp[63:32] != 32'd0 || w_sum > 34'sh0_7FFF_FFFF) begin
                    n_score = 32'h7FFF_FFFF;
                end else if (w_sum < -34'sh0_8000_0000) begin
                    n_score = 32'h8000_0000;
                end else begin
                    n_score = w_sum[31:0];
                end
                n_state = ucs_pkg::ST_CMP;
            end
            ucs_pkg::ST_CMP: begin
                if (!r_seen || $signed(r_score) > $signed(r_best)) begin
                    n_best = r_score;
                    n_bidx = ucs_pkg::IdxW'(r_pos);
                end
                n_seen = 1'b1;
                n_pos  = r_pos + 1'b1;
                if (r_last) begin
                    n_valid  = 1'b1;
                    n_oidx   = (!r_seen || $signed(r_score) > $signed(r_best)) ?
                               6'(r_pos) : 6'(r_bidx);
                    n_ofound = 1'b1;
                    n_oscore = (!r_seen || $signed(r_score) > $signed(r_best)) ?
                               r_score : r_best;
                    n_best   = 32'h8000_0000;
                    n_bidx   = '0;
                    n_pos    = '0;
                    n_seen   = 1'b0;
                end
                n_state = ucs_pkg::ST_IDLE;
            end
            default: n_state = ucs_pkg::ST_IDLE;
        endcase
    end

    assign o_busy       = (r_state != ucs_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_best_index = r_oidx;
    assign o_found      = r_ofound;
    assign o_best_score = r_oscore;

    // checks
    `UCS_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1,
        r_pos <= ucs_pkg::PosW'(ucs_pkg::MaxChildren))
    `UCS_ASSERT_IMPL(a_empty_result, i_clk, i_rst_n, r_valid && !r_ofound,
        r_oscore == 32'd0 && r_oidx == 6'd0)
    `UCS_ASSERT_NEXT(a_result_clears, i_clk, i_rst_n, n_valid, !r_seen && r_pos == '0)

endmodule

// ===== src/uct_child_select_unit.sv =====
// top level of the uct child select unit
// depends on ucs_pkg, ucs_sequencer
// One request per child: a scored child keeps busy high until its score is
// compared, and the next request is taken only once busy is low. The time is
// set by the shared iterative unit: the 64-step mean divide, 16 log squarings,
// the ln multiply, the 64-step ratio divide, the 32-step root, the weight
// multiply, then sum and compare. A child with a parent count of zero skips the
// log, ratio, root and weight steps. An unvisited child keeps busy high for one
// cycle; a child beyond the limit or an end marker does not raise busy. The
// result strobe o_valid lasts one cycle, comes in the cycle busy falls (or the
// cycle after an end marker is taken) and cannot be held off by the receiver.
module uct_child_select_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_child_reward_sum,
    input  logic [23:0] i_child_visits,
    input  logic [23:0] i_parent_visits,
    input  logic        i_last_child,
    input  logic        i_no_children,
    output logic        o_valid,
    output logic [5:0]  o_best_index,
    output logic        o_found,
    output logic [31:0] o_best_score
);

    logic [15:0] r_weight;

    // exploration weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= ucs_pkg::WeightReset;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    ucs_sequencer u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_weight          (r_weight),
        .i_child_reward_sum(i_child_reward_sum),
        .i_child_visits    (i_child_visits),
        .i_parent_visits   (i_parent_visits),
        .i_last_child      (i_last_child),
        .i_no_children     (i_no_children),
        .o_busy            (busy),
        .o_valid           (o_valid),
        .o_best_index      (o_best_index),
        .o_found           (o_found),
        .o_best_score      (o_best_score)
    );

endmodule
